### rtl/key_press_menu_controller_unit_macros.svh
// Assertion helpers for the key press menu controller.
// Both expect clk and rst_n in the scope where they are used.
`ifndef KEY_PRESS_MENU_CONTROLLER_UNIT_MACROS_SVH
`define KEY_PRESS_MENU_CONTROLLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPMC_CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPMC_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kpmc_pkg.sv
package kpmc_pkg;

  localparam int NUM_KEYS = 4;
  localparam int CNT_W    = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_MENU  = 3'd0,
    MODE_READY = 3'd1,
    MODE_RUN   = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_FAULT = 3'd4
  } mode_t;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_FAULT = 2'd2;
  localparam logic [1:0] FUNC_DONE  = 2'd3;

  localparam logic [2:0] REG_LONG_PRESS   = 3'd0;
  localparam logic [2:0] REG_STARTUP_WIN  = 3'd1;
  localparam logic [2:0] REG_LOWEST_TASK  = 3'd2;
  localparam logic [2:0] REG_HIGHEST_TASK = 3'd3;
  localparam logic [2:0] REG_DEFAULT_TASK = 3'd4;
  localparam logic [2:0] REG_TARGET_LIMIT = 3'd5;
  localparam logic [2:0] REG_SENSOR_MASK  = 3'd6;

  localparam logic [15:0] LONG_PRESS_RST   = 16'd100;
  localparam logic [15:0] STARTUP_WIN_RST  = 16'd200;
  localparam logic [2:0]  LOWEST_TASK_RST  = 3'd0;
  localparam logic [2:0]  HIGHEST_TASK_RST = 3'd4;
  localparam logic [2:0]  DEFAULT_TASK_RST = 3'd0;
  localparam logic [6:0]  TARGET_LIMIT_RST = 7'd120;
  localparam logic [7:0]  SENSOR_MASK_RST  = 8'd25;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [15:0] startup_window_ticks;
    logic [2:0]  lowest_task;
    logic [2:0]  highest_task;
    logic [2:0]  default_task;
    logic [6:0]  target_limit;
    logic [7:0]  sensor_task_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] key_levels;
    logic [2:0] start_task_id;
  } item_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0][CNT_W-1:0] cnt;
    logic [NUM_KEYS-1:0]            short_flags;
    logic [NUM_KEYS-1:0]            long_flags;
  } key_state_t;

  typedef struct packed {
    logic [2:0]        menu_state;
    logic [2:0]        selected_task;
    logic signed [7:0] target_pos;
    logic              adjust_window_open;
    logic              task_start_pulse;
    logic              task_stop_pulse;
    logic              pin_sensor_mode;
  } result_t;

endpackage

### rtl/kpmc_key_scan.sv
module kpmc_key_scan (
  input  kpmc_pkg::key_state_t            ks_in,
  input  logic [kpmc_pkg::NUM_KEYS-1:0]   key_levels,
  input  logic [kpmc_pkg::NUM_KEYS-1:0]   scan_en,
  input  logic [kpmc_pkg::CNT_W-1:0]      long_press_ticks,
  output kpmc_pkg::key_state_t            ks_out
);

  always_comb begin
    logic [kpmc_pkg::CNT_W-1:0] inc;
    ks_out = ks_in;
    inc    = '0;
    for (int k = 0; k < kpmc_pkg::NUM_KEYS; k++) begin
      if (scan_en[k]) begin
        if (key_levels[k]) begin
          inc = (ks_in.cnt[k] == kpmc_pkg::CNT_MAX) ? ks_in.cnt[k]
                                                     : ks_in.cnt[k] + 16'd1;
          // reaching the threshold raises long and restarts, so a held key repeats
          if (inc == long_press_ticks) begin
            ks_out.long_flags[k] = 1'b1;
            ks_out.cnt[k]        = '0;
          end else begin
            ks_out.cnt[k] = inc;
          end
        end else begin
          if ((ks_in.cnt[k] != '0) && (ks_in.cnt[k] < long_press_ticks)) begin
            ks_out.short_flags[k] = 1'b1;
          end
          ks_out.cnt[k] = '0;
        end
      end
    end
  end

endmodule

### rtl/kpmc_core.sv
`include "key_press_menu_controller_unit_macros.svh"

module kpmc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  kpmc_pkg::item_t   item,
  input  kpmc_pkg::cfg_t    cfg,
  output kpmc_pkg::result_t res
);

  kpmc_pkg::key_state_t ks_r, ks_scan, ks_nxt;
  kpmc_pkg::mode_t      mode_r, mode_nxt;
  logic [2:0]           task_r, task_nxt;
  logic signed [7:0]    tgt_r, tgt_nxt;
  logic [15:0]          boot_r, boot_nxt;
  logic                 window_r, window_nxt;
  logic                 pin_r, pin_nxt;
  logic                 start_pls, stop_pls;
  logic [kpmc_pkg::NUM_KEYS-1:0] scan_en;

  function automatic logic signed [7:0] clamp_tgt(input logic signed [8:0] v,
                                                  input logic [6:0] lim);
    logic signed [8:0] lim_s;
    logic signed [8:0] r;
    lim_s = $signed({2'b00, lim});
    r     = v;
    if (r < -lim_s) r = -lim_s;
    if (r > lim_s)  r = lim_s;
    return r[7:0];
  endfunction

  // only key 1 is scanned while a task runs
  assign scan_en = {{(kpmc_pkg::NUM_KEYS-1){mode_r != kpmc_pkg::MODE_RUN}}, 1'b1};

  kpmc_key_scan u_key_scan (
    .ks_in            (ks_r),
    .key_levels       (item.key_levels),
    .scan_en          (scan_en),
    .long_press_ticks (cfg.long_press_ticks),
    .ks_out           (ks_scan)
  );

  always_comb begin
    logic [kpmc_pkg::NUM_KEYS-1:0] sf;
    logic [kpmc_pkg::NUM_KEYS-1:0] lf;
    logic                          flush;
    mode_nxt   = mode_r;
    task_nxt   = task_r;
    tgt_nxt    = tgt_r;
    boot_nxt   = boot_r;
    window_nxt = window_r;
    pin_nxt    = pin_r;
    ks_nxt     = ks_r;
    start_pls  = 1'b0;
    stop_pls   = 1'b0;
    flush      = 1'b0;
    sf         = ks_scan.short_flags;
    lf         = ks_scan.long_flags;

    unique case (item.func)
      kpmc_pkg::FUNC_TICK: begin
        boot_nxt = (boot_r == kpmc_pkg::CNT_MAX) ? boot_r : boot_r + 16'd1;
        if (boot_nxt >= cfg.startup_window_ticks) window_nxt = 1'b0;

        unique case (mode_r)
          kpmc_pkg::MODE_MENU: begin
            if (sf[0] && (task_r < cfg.highest_task)) task_nxt = task_r + 3'd1;
            sf[0] = 1'b0;
            if (lf[0]) begin
              mode_nxt = kpmc_pkg::MODE_READY;
              flush    = 1'b1;
            end else begin
              if (sf[1] && (task_nxt > cfg.lowest_task)) task_nxt = task_nxt - 3'd1;
              sf[1] = 1'b0;
              if (lf[1]) begin
                task_nxt = cfg.default_task;
                tgt_nxt  = '0;
                lf[1]    = 1'b0;
              end
              if (window_nxt) begin
                if (sf[2]) begin
                  tgt_nxt = clamp_tgt($signed({tgt_nxt[7], tgt_nxt}) + 9'sd1,
                                      cfg.target_limit);
                  sf[2]   = 1'b0;
                end
                if (sf[3]) begin
                  tgt_nxt = clamp_tgt($signed({tgt_nxt[7], tgt_nxt}) - 9'sd1,
                                      cfg.target_limit);
                  sf[3]   = 1'b0;
                end
              end
            end
          end
          kpmc_pkg::MODE_READY: begin
            if (sf[0]) begin
              start_pls = 1'b1;
            end else if (sf[1]) begin
              mode_nxt = kpmc_pkg::MODE_MENU;
              flush    = 1'b1;
            end else begin
              lf[0] = 1'b0;
            end
          end
          kpmc_pkg::MODE_RUN: begin
            if (lf[0] || sf[2]) begin
              stop_pls = 1'b1;
              pin_nxt  = 1'b0;
              mode_nxt = kpmc_pkg::MODE_STOP;
              flush    = 1'b1;
            end
          end
          kpmc_pkg::MODE_STOP: begin
            if (sf[0]) begin
              mode_nxt = kpmc_pkg::MODE_READY;
              flush    = 1'b1;
            end else if (sf[1]) begin
              mode_nxt = kpmc_pkg::MODE_MENU;
              flush    = 1'b1;
            end
          end
          kpmc_pkg::MODE_FAULT: begin
            if (sf[0]) begin
              mode_nxt = kpmc_pkg::MODE_READY;
              flush    = 1'b1;
            end else if (lf[1]) begin
              mode_nxt = kpmc_pkg::MODE_MENU;
              flush    = 1'b1;
            end
          end
          default: ;
        endcase
        ks_nxt = '{cnt: ks_scan.cnt, short_flags: sf, long_flags: lf};
      end
      kpmc_pkg::FUNC_START: begin
        // drop a start whose id lies outside the selectable range
        if ((item.start_task_id >= cfg.lowest_task) &&
            (item.start_task_id <= cfg.highest_task)) begin
          task_nxt  = item.start_task_id;
          start_pls = 1'b1;
        end
      end
      kpmc_pkg::FUNC_FAULT: begin
        if (mode_r == kpmc_pkg::MODE_RUN) begin
          stop_pls = 1'b1;
          pin_nxt  = 1'b0;
        end
        mode_nxt = kpmc_pkg::MODE_FAULT;
        flush    = 1'b1;
      end
      kpmc_pkg::FUNC_DONE: begin
        if (mode_r == kpmc_pkg::MODE_RUN) begin
          pin_nxt  = 1'b0;
          mode_nxt = kpmc_pkg::MODE_STOP;
        end
      end
      default: ;
    endcase

    if (start_pls) begin
      if (cfg.sensor_task_mask[task_nxt]) pin_nxt = 1'b1;
      mode_nxt = kpmc_pkg::MODE_RUN;
      flush    = 1'b1;
    end

    if (flush) ks_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= kpmc_pkg::MODE_MENU;
    end else if (en) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r     <= '0;
      task_r   <= kpmc_pkg::DEFAULT_TASK_RST;
      tgt_r    <= '0;
      boot_r   <= '0;
      window_r <= 1'b1;
      pin_r    <= 1'b0;
    end else if (en) begin
      ks_r     <= ks_nxt;
      task_r   <= task_nxt;
      tgt_r    <= tgt_nxt;
      boot_r   <= boot_nxt;
      window_r <= window_nxt;
      pin_r    <= pin_nxt;
    end
  end

  assign res = '{
    menu_state:         mode_nxt,
    selected_task:      task_nxt,
    target_pos:         tgt_nxt,
    adjust_window_open: window_nxt,
    task_start_pulse:   start_pls,
    task_stop_pulse:    stop_pls,
    pin_sensor_mode:    pin_nxt
  };

  `KPMC_CHK_NOW(a_pulse_excl, en, !(start_pls && stop_pls), "start and stop pulse together")
  `KPMC_CHK_NEXT(a_start_runs, en && start_pls, mode_r == kpmc_pkg::MODE_RUN, "start did not enter running")
  `KPMC_CHK_NEXT(a_window_stays_shut, !window_r, !window_r, "adjust window reopened")
  `KPMC_CHK_NEXT(a_run_no_scan, en && (mode_r == kpmc_pkg::MODE_RUN) && (item.func == kpmc_pkg::FUNC_TICK), (ks_r.cnt[1] == $past(ks_r.cnt[1])) || (ks_r.cnt[1] == '0), "key 2 scanned while running")

endmodule

### rtl/key_press_menu_controller_unit.sv
// An accepted input item is held in the input register, goes through one logic pass and
// is captured in the result register once that register is free or being drained.
// Throughput: one item per cycle when not stalled; the menu state updates in that single pass.
// A stalled result register holds its item while the input register still takes one more.
// Reset (rst_n, synchronous, active low) restores configuration registers, counters, flags
// and menu to their reset values; both channels come up empty.
module key_press_menu_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] key_levels, [6:4] start_task_id, [7] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] menu_state, [5:3] selected_task, [13:6] target_pos,
                                  // [14] adjust_window_open, [15] task_start_pulse,
                                  // [16] task_stop_pulse, [17] pin_sensor_mode, [23:18] zero
);

  kpmc_pkg::cfg_t    cfg_r;
  kpmc_pkg::item_t   item_r;
  kpmc_pkg::result_t res, res_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{
        long_press_ticks:     kpmc_pkg::LONG_PRESS_RST,
        startup_window_ticks: kpmc_pkg::STARTUP_WIN_RST,
        lowest_task:          kpmc_pkg::LOWEST_TASK_RST,
        highest_task:         kpmc_pkg::HIGHEST_TASK_RST,
        default_task:         kpmc_pkg::DEFAULT_TASK_RST,
        target_limit:         kpmc_pkg::TARGET_LIMIT_RST,
        sensor_task_mask:     kpmc_pkg::SENSOR_MASK_RST
      };
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kpmc_pkg::REG_LONG_PRESS:   cfg_r.long_press_ticks     <= cfg_wdata;
        kpmc_pkg::REG_STARTUP_WIN:  cfg_r.startup_window_ticks <= cfg_wdata;
        kpmc_pkg::REG_LOWEST_TASK:  cfg_r.lowest_task          <= cfg_wdata[2:0];
        kpmc_pkg::REG_HIGHEST_TASK: cfg_r.highest_task         <= cfg_wdata[2:0];
        kpmc_pkg::REG_DEFAULT_TASK: cfg_r.default_task         <= cfg_wdata[2:0];
        kpmc_pkg::REG_TARGET_LIMIT: cfg_r.target_limit         <= cfg_wdata[6:0];
        kpmc_pkg::REG_SENSOR_MASK:  cfg_r.sensor_task_mask     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // process the held item when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{func: in_tuser, key_levels: in_tdata[3:0], start_task_id: in_tdata[6:4]};
    end
  end

  kpmc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.pin_sensor_mode, res_r.task_stop_pulse,
                       res_r.task_start_pulse, res_r.adjust_window_open, res_r.target_pos,
                       res_r.selected_task, res_r.menu_state};

endmodule

### test/key_press_menu_controller_unit_test.sv
module key_press_menu_controller_unit_test;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [3:0] key_levels, [6:4] start_task_id, [7] zero
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [2:0] menu_state, [5:3] selected_task, [13:6] target_pos,
                                // [14] adjust_window_open, [15] task_start_pulse,
                                // [16] task_stop_pulse, [17] pin_sensor_mode, [23:18] zero

  key_press_menu_controller_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("key_press_menu_controller_unit_test: done, errors");
    $finish;
  end

  // Register copies
  logic [15:0] thr_long, win_ticks;
  logic [2:0]  task_lo, task_hi, task_dflt;
  logic [6:0]  tgt_lim;
  logic [7:0]  sens_mask;

  // Menu and key state
  logic [15:0] key_cnt [4];
  logic [3:0]  short_f, long_f;
  kpmc_pkg::mode_t menu_mode;
  logic [2:0]  task_no;
  int          target_val;
  logic [15:0] boot_cnt;
  logic        window_open, pin_sensor, start_p, stop_p;

  kpmc_pkg::item_t   key_items_pending [$];
  kpmc_pkg::result_t menu_outputs_due [$];

  int    mismatches = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_writes = 0;
  int    starts_seen = 0;
  int    stops_seen = 0;
  logic  steady = 1'b0;

  kpmc_pkg::item_t cur_item = '0;
  logic  offer;
  int    gap_left, burst_left;
  int    hold_left = 0;
  int    pat = 0;
  int    pat_left = 0;
  logic  rdy;

  function automatic void clear_keys();
    short_f = '0;
    long_f = '0;
    for (int k = 0; k < 4; k++) key_cnt[k] = '0;
  endfunction

  function automatic void reset_model();
    thr_long = kpmc_pkg::LONG_PRESS_RST;
    win_ticks = kpmc_pkg::STARTUP_WIN_RST;
    task_lo = kpmc_pkg::LOWEST_TASK_RST;
    task_hi = kpmc_pkg::HIGHEST_TASK_RST;
    task_dflt = kpmc_pkg::DEFAULT_TASK_RST;
    tgt_lim = kpmc_pkg::TARGET_LIMIT_RST;
    sens_mask = kpmc_pkg::SENSOR_MASK_RST;
    clear_keys();
    menu_mode = kpmc_pkg::MODE_MENU;
    task_no = task_dflt;
    target_val = 0;
    boot_cnt = '0;
    window_open = 1'b1;
    pin_sensor = 1'b0;
  endfunction

  function automatic bit take_short(input int k);
    take_short = short_f[k];
    short_f[k] = 1'b0;
  endfunction

  function automatic bit take_long(input int k);
    take_long = long_f[k];
    long_f[k] = 1'b0;
  endfunction

  function automatic void scan_key(input int k, input logic down);
    if (down) begin
      if (key_cnt[k] != kpmc_pkg::CNT_MAX) key_cnt[k] = key_cnt[k] + 16'd1;
      // restart on the threshold so a held key repeats
      if (key_cnt[k] == thr_long) begin
        long_f[k] = 1'b1;
        key_cnt[k] = '0;
      end
    end else begin
      if (key_cnt[k] != 0 && key_cnt[k] < thr_long) short_f[k] = 1'b1;
      key_cnt[k] = '0;
    end
  endfunction

  function automatic void adjust_target(input int delta);
    int lim;
    lim = int'(tgt_lim);
    target_val = target_val + delta;
    if (target_val < -lim) target_val = -lim;
    if (target_val > lim) target_val = lim;
  endfunction

  function automatic void start_selected();
    if (sens_mask[task_no]) pin_sensor = 1'b1;
    menu_mode = kpmc_pkg::MODE_RUN;
    clear_keys();
    start_p = 1'b1;
  endfunction

  function automatic void stop_running();
    stop_p = 1'b1;
    pin_sensor = 1'b0;
    menu_mode = kpmc_pkg::MODE_STOP;
    clear_keys();
  endfunction

  // Flags not used in the current mode stay pending, except a long key 1 in ready, which is dropped.
  function automatic void consume_flags();
    case (menu_mode)
      kpmc_pkg::MODE_MENU: begin
        if (take_short(0) && task_no < task_hi) task_no = task_no + 3'd1;
        if (take_long(0)) begin
          menu_mode = kpmc_pkg::MODE_READY;
          clear_keys();
          return;
        end
        if (take_short(1) && task_no > task_lo) task_no = task_no - 3'd1;
        if (take_long(1)) begin
          task_no = task_dflt;
          target_val = 0;
        end
        if (window_open) begin
          if (take_short(2)) adjust_target(1);
          if (take_short(3)) adjust_target(-1);
        end
      end
      kpmc_pkg::MODE_READY: begin
        if (take_short(0)) begin
          start_selected();
          return;
        end
        if (take_short(1)) begin
          menu_mode = kpmc_pkg::MODE_MENU;
          clear_keys();
          return;
        end
        void'(take_long(0));
      end
      kpmc_pkg::MODE_RUN: begin
        if (take_long(0)) begin
          stop_running();
          return;
        end
        if (take_short(2)) stop_running();
      end
      kpmc_pkg::MODE_STOP: begin
        if (take_short(0)) begin
          menu_mode = kpmc_pkg::MODE_READY;
          clear_keys();
          return;
        end
        if (take_short(1)) begin
          menu_mode = kpmc_pkg::MODE_MENU;
          clear_keys();
        end
      end
      kpmc_pkg::MODE_FAULT: begin
        if (take_short(0)) begin
          menu_mode = kpmc_pkg::MODE_READY;
          clear_keys();
          return;
        end
        if (take_long(1)) begin
          menu_mode = kpmc_pkg::MODE_MENU;
          clear_keys();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic kpmc_pkg::result_t predict_menu_outputs(input kpmc_pkg::item_t it);
    kpmc_pkg::result_t r;
    start_p = 1'b0;
    stop_p = 1'b0;
    case (it.func)
      kpmc_pkg::FUNC_TICK: begin
        scan_key(0, it.key_levels[0]);
        // keys two to four are not scanned while a task runs
        if (menu_mode != kpmc_pkg::MODE_RUN)
          for (int k = 1; k < 4; k++) scan_key(k, it.key_levels[k]);
        if (boot_cnt != kpmc_pkg::CNT_MAX) boot_cnt = boot_cnt + 16'd1;
        if (boot_cnt >= win_ticks) window_open = 1'b0;
        consume_flags();
      end
      kpmc_pkg::FUNC_START: begin
        if (it.start_task_id >= task_lo && it.start_task_id <= task_hi) begin
          task_no = it.start_task_id;
          start_selected();
        end
      end
      kpmc_pkg::FUNC_FAULT: begin
        if (menu_mode == kpmc_pkg::MODE_RUN) begin
          stop_p = 1'b1;
          pin_sensor = 1'b0;
        end
        menu_mode = kpmc_pkg::MODE_FAULT;
        clear_keys();
      end
      default: begin
        if (menu_mode == kpmc_pkg::MODE_RUN) begin
          pin_sensor = 1'b0;
          menu_mode = kpmc_pkg::MODE_STOP;
        end
      end
    endcase
    r.menu_state = menu_mode;
    r.selected_task = task_no;
    r.target_pos = target_val[7:0];
    r.adjust_window_open = window_open;
    r.task_start_pulse = start_p;
    r.task_stop_pulse = stop_p;
    r.pin_sensor_mode = pin_sensor;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH %s", msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                n_results, name, got, want));
  endtask

  task automatic check_output(input logic [23:0] word);
    kpmc_pkg::result_t got, want;
    got.menu_state = word[2:0];
    got.selected_task = word[5:3];
    got.target_pos = word[13:6];
    got.adjust_window_open = word[14];
    got.task_start_pulse = word[15];
    got.task_stop_pulse = word[16];
    got.pin_sensor_mode = word[17];
    if (menu_outputs_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
    end else begin
      want = menu_outputs_due.pop_front();
      compare_field("menu_state", int'(got.menu_state), int'(want.menu_state));
      compare_field("selected_task", int'(got.selected_task), int'(want.selected_task));
      compare_field("target_pos", int'(got.target_pos), int'(want.target_pos));
      compare_field("adjust_window_open", int'(got.adjust_window_open),
                    int'(want.adjust_window_open));
      compare_field("task_start_pulse", int'(got.task_start_pulse),
                    int'(want.task_start_pulse));
      compare_field("task_stop_pulse", int'(got.task_stop_pulse),
                    int'(want.task_stop_pulse));
      compare_field("pin_sensor_mode", int'(got.pin_sensor_mode),
                    int'(want.pin_sensor_mode));
    end
    if (got.task_start_pulse) starts_seen++;
    if (got.task_stop_pulse) stops_seen++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        menu_outputs_due.push_back(predict_menu_outputs(cur_item));
        n_items++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
        end else if (key_items_pending.size() > 0) begin
          cur_item = key_items_pending.pop_front();
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            gap_left = $urandom_range(0, 10);
          end
        end
      end
      in_tvalid <= offer;
      in_tdata <= {1'b0, cur_item.start_task_id, cur_item.key_levels};
      in_tuser <= cur_item.func;
    end
  end

  // Receiver: checks results and stalls on its own pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_output(out_tdata);
        n_results++;
        // long hold-off so the block backs up into its input
        if (n_results % 700 == 0 && !steady) hold_left = 150;
      end
      if (steady) begin
        rdy = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat = $urandom_range(0, 3);
          pat_left = $urandom_range(8, 80);
        end else begin
          pat_left--;
        end
        case (pat)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  task automatic queue_key_item(input logic [1:0] f, input logic [3:0] keys,
                                input logic [2:0] id);
    kpmc_pkg::item_t it;
    it.func = f;
    it.key_levels = keys;
    it.start_task_id = id;
    key_items_pending.push_back(it);
  endtask

  task automatic queue_ticks(input logic [3:0] keys, input int count);
    repeat (count) queue_key_item(kpmc_pkg::FUNC_TICK, keys, 3'($urandom_range(0, 7)));
  endtask

  task automatic queue_random_items(input int n);
    int made, r, hold, rel, thr_cap;
    logic [1:0] f;
    logic [3:0] keys;
    made = 0;
    thr_cap = (thr_long == 0 || thr_long > 8) ? 8 : int'(thr_long);
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        case ($urandom_range(0, 3))
          0, 1: f = kpmc_pkg::FUNC_START;
          2: f = kpmc_pkg::FUNC_FAULT;
          default: f = kpmc_pkg::FUNC_DONE;
        endcase
        queue_key_item(f, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
        made++;
      end else if (r < 20) begin
        queue_ticks(4'($urandom_range(0, 15)), 1);
        made++;
      end else begin
        // press and release, lengths around the long press threshold
        if (r < 60) keys = 4'b0001;
        else if (r < 85) keys = 4'b0001 << $urandom_range(1, 3);
        else keys = 4'($urandom_range(1, 15));
        hold = $urandom_range(1, 2 * thr_cap + 1);
        rel = $urandom_range(1, 2);
        queue_ticks(keys, hold);
        queue_ticks(4'b0000, rel);
        made += hold + rel;
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      kpmc_pkg::REG_LONG_PRESS:   thr_long = val;
      kpmc_pkg::REG_STARTUP_WIN:  win_ticks = val;
      kpmc_pkg::REG_LOWEST_TASK:  task_lo = val[2:0];
      kpmc_pkg::REG_HIGHEST_TASK: task_hi = val[2:0];
      kpmc_pkg::REG_DEFAULT_TASK: task_dflt = val[2:0];
      kpmc_pkg::REG_TARGET_LIMIT: tgt_lim = val[6:0];
      kpmc_pkg::REG_SENSOR_MASK:  sens_mask = val[7:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic program_all(input logic [15:0] lp, input logic [15:0] win,
                             input logic [2:0] lo, input logic [2:0] hi,
                             input logic [2:0] dflt, input logic [6:0] lim,
                             input logic [7:0] mask);
    write_reg(kpmc_pkg::REG_LONG_PRESS, lp);
    write_reg(kpmc_pkg::REG_STARTUP_WIN, win);
    write_reg(kpmc_pkg::REG_LOWEST_TASK, {13'd0, lo});
    write_reg(kpmc_pkg::REG_HIGHEST_TASK, {13'd0, hi});
    write_reg(kpmc_pkg::REG_DEFAULT_TASK, {13'd0, dflt});
    write_reg(kpmc_pkg::REG_TARGET_LIMIT, {9'd0, lim});
    write_reg(kpmc_pkg::REG_SENSOR_MASK, {8'd0, mask});
  endtask

  // Drain everything in flight, then let the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (key_items_pending.size() != 0 || in_tvalid || menu_outputs_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : main_seq
    int seg;
    logic [15:0] lp, win;
    logic [2:0]  lo, hi, dflt;
    logic [6:0]  lim;
    logic [7:0]  mask;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through every mode
    program_all(16'd3, 16'hFFFF, 3'd0, 3'd7, 3'd5, 7'd127, 8'hA5);
    @(negedge clk);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b0100, 1);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b1000, 1);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b0001, 1);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b0010, 3);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b0001, 3);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b0001, 1);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b1111, 1);
    queue_key_item(kpmc_pkg::FUNC_DONE, 4'b0000, 3'd0);
    queue_ticks(4'b0000, 1);
    queue_key_item(kpmc_pkg::FUNC_START, 4'b1111, 3'd7);
    queue_key_item(kpmc_pkg::FUNC_FAULT, 4'b0000, 3'd0);
    queue_key_item(kpmc_pkg::FUNC_START, 4'b0000, 3'd2);
    queue_ticks(4'b0001, 3);
    queue_ticks(4'b0000, 1);
    queue_ticks(4'b0010, 1);
    queue_ticks(4'b0000, 1);

    // Threshold lowered while a key is held: no long flag, no short on release
    wait_idle();
    write_reg(kpmc_pkg::REG_LONG_PRESS, 16'd50);
    @(negedge clk);
    queue_ticks(4'b0001, 20);
    wait_idle();
    write_reg(kpmc_pkg::REG_LONG_PRESS, 16'd10);
    @(negedge clk);
    queue_ticks(4'b0001, 20);
    queue_ticks(4'b0000, 1);

    // Walk the target to both ends of the widest clamp
    wait_idle();
    write_reg(kpmc_pkg::REG_LONG_PRESS, 16'd3);
    write_reg(kpmc_pkg::REG_TARGET_LIMIT, 16'd127);
    @(negedge clk);
    queue_key_item(kpmc_pkg::FUNC_FAULT, 4'b0000, 3'd0);
    queue_ticks(4'b0010, 3);
    queue_ticks(4'b0000, 1);
    repeat (130) begin
      queue_ticks(4'b0100, 1);
      queue_ticks(4'b0000, 1);
    end
    repeat (260) begin
      queue_ticks(4'b1000, 1);
      queue_ticks(4'b0000, 1);
    end

    for (seg = 0; seg < 8; seg++) begin
      wait_idle();
      lp = 16'($urandom_range(2, 6));
      win = 16'hFFFF;
      lo = 3'($urandom_range(0, 7));
      hi = 3'($urandom_range(0, 7));
      dflt = 3'($urandom_range(0, 7));
      lim = 7'($urandom_range(0, 12));
      mask = 8'($urandom_range(0, 255));
      case (seg)
        0: begin lp = 16'd3; lo = 3'd0; hi = 3'd7; lim = 7'd127; mask = 8'h00; end
        1: begin lp = 16'd1; lo = 3'd3; hi = 3'd3; lim = 7'd0; mask = 8'hFF; end
        2: begin lp = 16'd5; lo = 3'd5; hi = 3'd2; end
        4: begin lp = 16'd0; lo = 3'd0; hi = 3'd7; end
        6: begin lp = 16'hFFFF; win = 16'd0; end
        7: win = 16'd200;
        default: ;
      endcase
      program_all(lp, win, lo, hi, dflt, lim, mask);
      @(negedge clk);
      queue_random_items(130);
    end

    // Leave the fault state with a long key 2, then run back to back
    wait_idle();
    write_reg(kpmc_pkg::REG_LONG_PRESS, 16'd2);
    @(negedge clk);
    queue_key_item(kpmc_pkg::FUNC_FAULT, 4'b0000, 3'd0);
    queue_ticks(4'b0010, 2);
    queue_ticks(4'b0000, 1);
    wait_idle();
    steady <= 1'b1;
    @(negedge clk);
    repeat (100) queue_key_item(kpmc_pkg::FUNC_TICK, {3'($urandom_range(0, 7)), 1'b1},
                                3'($urandom_range(0, 7)));
    wait_idle();

    $display("summary: %0d items sent, %0d results checked, %0d register writes",
             n_items, n_results, n_writes);
    $display("summary: %0d task starts and %0d stop pulses observed", starts_seen, stops_seen);
    if (mismatches == 0) begin
      $display("key_press_menu_controller_unit_test: done, clean");
    end else begin
      $display("key_press_menu_controller_unit_test: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/kpmc_pkg.sv
rtl/kpmc_key_scan.sv
rtl/kpmc_core.sv
rtl/key_press_menu_controller_unit.sv
test/key_press_menu_controller_unit_test.sv
